[hw/rtl/forth_two_stack_alu_core_assert.svh]
// ----------------------------------------------------------------------------
// forth_two_stack_alu_core_assert.svh
// Assertion macros shared by the stack ALU RTL.
// ----------------------------------------------------------------------------
`ifndef FORTH_TWO_STACK_ALU_CORE_ASSERT_SVH
`define FORTH_TWO_STACK_ALU_CORE_ASSERT_SVH

// same-cycle implication
`define FTSA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("forth_two_stack_alu_core: assertion failed");

// next-cycle implication
`define FTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("forth_two_stack_alu_core: assertion failed");

`endif

[hw/rtl/ftsa_pkg.sv]
// ----------------------------------------------------------------------------
// ftsa_pkg
// Types, constants and opcode tables for the two-stack Forth ALU.
// ----------------------------------------------------------------------------
package ftsa_pkg;

    localparam int CELL_W          = 64;  // port width of a cell
    localparam int CNT_W           = 7;   // port width of a depth
    localparam int FUNC_W          = 5;
    localparam int FAULT_W         = 3;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int DEF_CELL_BITS   = 64;

    typedef enum logic [FUNC_W-1:0] {
        OP_LIT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DUP, OP_2DUP,
        OP_DROP, OP_2DROP, OP_SWAP, OP_NIP, OP_TUCK, OP_OVER, OP_ROT, OP_PICK,
        OP_LSHIFT, OP_RSHIFT, OP_EQ, OP_LT, OP_GT, OP_TRUE, OP_FALSE, OP_AND,
        OP_OR, OP_XOR, OP_INVERT, OP_NEGATE, OP_TOR, OP_RFROM, OP_RFETCH, OP_ZTEST
    } op_t;

    typedef enum logic [FAULT_W-1:0] {
        FLT_OK       = 3'd0,
        FLT_DATA_OVF = 3'd1,
        FLT_DATA_UNF = 3'd2,
        FLT_RET_OVF  = 3'd3,
        FLT_RET_UNF  = 3'd4,
        FLT_DIV_ZERO = 3'd5,
        FLT_PICK     = 3'd6
    } fault_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_LOAD, ST_PICK_RD, ST_PICK_LD, ST_EXEC,
        ST_ITER, ST_WRITE, ST_TOP_RD, ST_FINISH
    } state_t;

    // data stack cells consumed
    function automatic logic [1:0] op_pops(op_t op);
        logic [1:0] n;
        unique case (op)
            OP_LIT, OP_TRUE, OP_FALSE, OP_RFROM, OP_RFETCH: n = 2'd0;
            OP_DUP, OP_DROP, OP_PICK, OP_INVERT, OP_NEGATE,
            OP_TOR, OP_ZTEST:                               n = 2'd1;
            OP_ROT:                                         n = 2'd3;
            default:                                        n = 2'd2;
        endcase
        return n;
    endfunction

    // data stack cells produced
    function automatic logic [2:0] op_pushes(op_t op);
        logic [2:0] n;
        unique case (op)
            OP_DROP, OP_2DROP, OP_TOR, OP_ZTEST: n = 3'd0;
            OP_DUP, OP_SWAP:                     n = 3'd2;
            OP_TUCK, OP_OVER, OP_ROT:            n = 3'd3;
            OP_2DUP:                             n = 3'd4;
            default:                             n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

[hw/rtl/ftsa_req_if.sv]
// ----------------------------------------------------------------------------
// ftsa_req_if
// Request channel: one Forth primitive with its literal.
// ----------------------------------------------------------------------------
interface ftsa_req_if;
    import ftsa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [CELL_W-1:0] literal;

    modport source (output valid, func, literal, input ready);
    modport sink   (input valid, func, literal, output ready);
endinterface

[hw/rtl/ftsa_rsp_if.sv]
// ----------------------------------------------------------------------------
// ftsa_rsp_if
// Response channel: stack status after one primitive.
// ----------------------------------------------------------------------------
interface ftsa_rsp_if;
    import ftsa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CELL_W-1:0] top_value;
    logic [CNT_W-1:0]         data_depth;
    logic [CNT_W-1:0]         return_depth;
    logic                     popped_zero;
    logic [FAULT_W-1:0]       fault;

    modport source (output valid, top_value, data_depth, return_depth, popped_zero, fault,
                    input ready);
    modport sink   (input valid, top_value, data_depth, return_depth, popped_zero, fault,
                    output ready);
endinterface

[hw/rtl/forth_two_stack_alu_core.sv]
// ----------------------------------------------------------------------------
// forth_two_stack_alu_core
// Forth primitive engine on a data stack and a return stack in RAM.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   func, literal
//  rsp      out  top_value, data_depth, return_depth, popped_zero, fault
//
//  One request at a time; req.ready is high only while idle.
//  Steps: accept, read and load per fetched cell (popped cells; r> and r@
//  fetch the return top), execute, write per pushed cell (min 1), top read,
//  response load; pick adds a read and load, mul/div/mod add CELL_BITS
//  steps. Count faults go from accept to response load; pick/divide faults
//  skip the write and top read. A held response stalls completion of the
//  next request in its last cycle. Reset clears both depths, not stack RAM.
// ----------------------------------------------------------------------------
module forth_two_stack_alu_core #(
    parameter int STACK_DEPTH = ftsa_pkg::DEF_STACK_DEPTH,
    parameter int CELL_BITS   = ftsa_pkg::DEF_CELL_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    ftsa_req_if.sink    req,
    ftsa_rsp_if.source  rsp
);
    import ftsa_pkg::*;

    localparam int N  = CELL_BITS;
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = $clog2(CELL_BITS);
    localparam int IW = $clog2(CELL_BITS + 1);

    // stack RAMs
    logic [N-1:0] data_mem [STACK_DEPTH];
    logic [N-1:0] ret_mem  [STACK_DEPTH];
    logic [N-1:0] data_rd_reg, ret_rd_reg;
    logic          data_we, ret_we;
    logic [AW-1:0] data_wa, data_ra, ret_wa, ret_ra;
    logic [N-1:0]  data_wd;

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        data_rd_reg <= data_mem[data_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ret_we)
        begin
            ret_mem[ret_wa] <= data_rd_reg;
        end
        ret_rd_reg <= ret_mem[ret_ra];
    end

    // control state
    state_t        state_reg, state_next;
    logic [CW-1:0] dcnt_reg, dcnt_next, rcnt_reg, rcnt_next;
    logic          out_valid_reg, out_valid_next;

    // payload state
    op_t           op_reg, op_next;
    logic [N-1:0]  lit_reg, lit_next;
    logic [1:0]    nfetch_reg, nfetch_next;
    logic [2:0]    npush_reg, npush_next;
    logic [1:0]    k_reg, k_next;
    logic [1:0]    j_reg, j_next;
    logic [CW-1:0] base_reg, base_next;
    logic [N-1:0]  s0_reg, s0_next, s1_reg, s1_next, s2_reg, s2_next;
    logic [N-1:0]  res_reg, res_next;
    logic [N-1:0]  acc_reg, acc_next;
    logic [N-1:0]  x_reg, x_next, y_reg, y_next;
    logic [IW-1:0] it_reg, it_next;
    logic          zf_reg, zf_next;
    fault_t        flt_reg, flt_next;
    logic signed [CELL_W-1:0] top_out_reg, top_out_next;
    logic [CNT_W-1:0] dd_out_reg, dd_out_next, rd_out_reg, rd_out_next;
    logic          zf_out_reg, zf_out_next;
    fault_t        flt_out_reg, flt_out_next;

    // accept-time decode
    op_t        in_op;
    logic [1:0] in_pops;
    logic [2:0] in_push;
    logic [CW:0] in_after;
    fault_t     in_fault;

    assign in_op    = op_t'(req.func);
    assign in_pops  = op_pops(in_op);
    assign in_push  = op_pushes(in_op);
    assign in_after = {1'b0, dcnt_reg} - (CW+1)'(in_pops) + (CW+1)'(in_push);

    always_comb
    begin
        priority if (dcnt_reg < CW'(in_pops))
            in_fault = FLT_DATA_UNF;
        else if (in_op == OP_TOR && rcnt_reg == CW'(STACK_DEPTH))
            in_fault = FLT_RET_OVF;
        else if ((in_op == OP_RFROM || in_op == OP_RFETCH) && rcnt_reg == '0)
            in_fault = FLT_RET_UNF;
        else if (in_after > (CW+1)'(STACK_DEPTH))
            in_fault = FLT_DATA_OVF;
        else
            in_fault = FLT_OK;
    end

    // combinational ALU: a = second, b = top
    logic [N-1:0] alu_res, mag_a, mag_b, div_t_sub;
    logic         sh_big;
    logic [N:0]   div_t;
    logic         div_ge;

    assign sh_big = s0_reg[N-1] || (s0_reg >= N'(CELL_BITS));
    assign mag_a  = s1_reg[N-1] ? (N'(0) - s1_reg) : s1_reg;
    assign mag_b  = s0_reg[N-1] ? (N'(0) - s0_reg) : s0_reg;

    always_comb
    begin
        unique case (op_reg)
            OP_LIT:    alu_res = lit_reg;
            OP_ADD:    alu_res = s1_reg + s0_reg;
            OP_SUB:    alu_res = s1_reg - s0_reg;
            OP_LSHIFT: alu_res = sh_big ? '0 : (s1_reg << s0_reg[SW-1:0]);
            OP_RSHIFT: alu_res = sh_big ? '0 : (s1_reg >> s0_reg[SW-1:0]);
            OP_EQ:     alu_res = (s1_reg == s0_reg) ? '1 : '0;
            OP_LT:     alu_res = ($signed(s1_reg) < $signed(s0_reg)) ? '1 : '0;
            OP_GT:     alu_res = ($signed(s1_reg) > $signed(s0_reg)) ? '1 : '0;
            OP_TRUE:   alu_res = '1;
            OP_AND:    alu_res = s1_reg & s0_reg;
            OP_OR:     alu_res = s1_reg | s0_reg;
            OP_XOR:    alu_res = s1_reg ^ s0_reg;
            OP_INVERT: alu_res = ~s0_reg;
            OP_NEGATE: alu_res = N'(0) - s0_reg;
            OP_PICK:   alu_res = s1_reg;
            OP_RFROM, OP_RFETCH: alu_res = s0_reg;
            default:   alu_res = '0;
        endcase
    end

    // restoring divide step
    assign div_t     = {acc_reg, x_reg[N-1]};
    assign div_ge    = div_t >= {1'b0, y_reg};
    assign div_t_sub = N'(div_t - {1'b0, y_reg});

    // stack shuffle: value of the j-th push
    always_comb
    begin
        unique case (op_reg)
            OP_DUP, OP_NIP: data_wd = s0_reg;
            OP_2DUP:        data_wd = j_reg[0] ? s0_reg : s1_reg;
            OP_SWAP:        data_wd = (j_reg == 2'd0) ? s0_reg : s1_reg;
            OP_TUCK:        data_wd = (j_reg == 2'd1) ? s1_reg : s0_reg;
            OP_OVER:        data_wd = (j_reg == 2'd1) ? s0_reg : s1_reg;
            OP_ROT:         data_wd = (j_reg == 2'd0) ? s1_reg :
                                      (j_reg == 2'd1) ? s0_reg : s2_reg;
            default:        data_wd = res_reg;
        endcase
    end

    assign data_wa = AW'(base_reg + CW'(j_reg));
    assign ret_wa  = AW'(rcnt_reg);
    assign ret_ra  = AW'(rcnt_reg - CW'(1));

    always_comb
    begin
        unique case (state_reg)
            ST_FETCH:   data_ra = AW'(dcnt_reg - CW'(1) - CW'(k_reg));
            ST_PICK_RD: data_ra = AW'(dcnt_reg - CW'(2) - s0_reg[CW-1:0]);
            default:    data_ra = AW'(dcnt_reg - CW'(1));
        endcase
    end

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.top_value  = top_out_reg;
    assign rsp.data_depth = dd_out_reg;
    assign rsp.return_depth = rd_out_reg;
    assign rsp.popped_zero  = zf_out_reg;
    assign rsp.fault        = flt_out_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        dcnt_next      = dcnt_reg;
        rcnt_next      = rcnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        op_next        = op_reg;
        lit_next       = lit_reg;
        nfetch_next    = nfetch_reg;
        npush_next     = npush_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        base_next      = base_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        res_next       = res_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        it_next        = it_reg;
        zf_next        = zf_reg;
        flt_next       = flt_reg;
        top_out_next   = top_out_reg;
        dd_out_next    = dd_out_reg;
        rd_out_next    = rd_out_reg;
        zf_out_next    = zf_out_reg;
        flt_out_next   = flt_out_reg;
        data_we        = 1'b0;
        ret_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = in_op;
                    lit_next    = N'(req.literal);
                    npush_next  = in_push;
                    base_next   = dcnt_reg - CW'(in_pops);
                    nfetch_next = (in_op == OP_RFROM || in_op == OP_RFETCH) ? 2'd1 : in_pops;
                    k_next      = 2'd0;
                    j_next      = 2'd0;
                    zf_next     = 1'b0;
                    flt_next    = in_fault;
                    if (in_fault != FLT_OK)
                    begin
                        dcnt_next  = '0;
                        rcnt_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else if (nfetch_next == 2'd0)
                        state_next = ST_EXEC;
                    else
                        state_next = ST_FETCH;
                end
            end

            ST_FETCH:
                state_next = ST_LOAD;

            ST_LOAD:
            begin
                unique case (k_reg)
                    2'd0:    s0_next = (op_reg == OP_RFROM || op_reg == OP_RFETCH)
                                       ? ret_rd_reg : data_rd_reg;
                    2'd1:    s1_next = data_rd_reg;
                    default: s2_next = data_rd_reg;
                endcase
                k_next = k_reg + 2'd1;
                if (k_next != nfetch_reg)
                    state_next = ST_FETCH;
                else if (op_reg == OP_PICK)
                begin
                    // index must be below the depth left after popping it
                    if (s0_next[N-1] || s0_next >= N'(dcnt_reg - CW'(1)))
                    begin
                        flt_next   = FLT_PICK;
                        dcnt_next  = '0;
                        rcnt_next  = '0;
                        state_next = ST_FINISH;
                    end
                    else
                        state_next = ST_PICK_RD;
                end
                else
                    state_next = ST_EXEC;
            end

            ST_PICK_RD:
                state_next = ST_PICK_LD;

            ST_PICK_LD:
            begin
                s1_next    = data_rd_reg;
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                res_next   = alu_res;
                state_next = ST_WRITE;
                it_next    = '0;
                unique case (op_reg)
                    OP_MUL:
                    begin
                        acc_next   = '0;
                        x_next     = s1_reg;
                        y_next     = s0_reg;
                        state_next = ST_ITER;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (s0_reg == '0)
                        begin
                            flt_next   = FLT_DIV_ZERO;
                            dcnt_next  = '0;
                            rcnt_next  = '0;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            acc_next   = '0;
                            x_next     = mag_a;
                            y_next     = mag_b;
                            state_next = ST_ITER;
                        end
                    end
                    OP_TOR:
                    begin
                        // popped cell is still in the read register
                        ret_we    = 1'b1;
                        rcnt_next = rcnt_reg + CW'(1);
                    end
                    OP_RFROM:
                        rcnt_next = rcnt_reg - CW'(1);
                    OP_ZTEST:
                        zf_next = (s0_reg == '0);
                    default:
                    begin
                    end
                endcase
            end

            ST_ITER:
            begin
                if (op_reg == OP_MUL)
                begin
                    acc_next = acc_reg + (y_reg[0] ? x_reg : N'(0));
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                end
                else
                begin
                    acc_next = div_ge ? div_t_sub : div_t[N-1:0];
                    x_next   = {x_reg[N-2:0], div_ge};
                end
                it_next = it_reg + IW'(1);
                if (it_reg == IW'(CELL_BITS - 1))
                begin
                    unique case (op_reg)
                        OP_MUL:
                            res_next = acc_next;
                        OP_DIV:
                            res_next = (s1_reg[N-1] ^ s0_reg[N-1]) ? N'(0) - x_next : x_next;
                        default:
                            res_next = s1_reg[N-1] ? N'(0) - acc_next : acc_next;
                    endcase
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                if (npush_reg == 3'd0 || {1'b0, j_reg} + 3'd1 == npush_reg)
                begin
                    dcnt_next  = base_reg + CW'(npush_reg);
                    state_next = ST_TOP_RD;
                end
                data_we = (npush_reg != 3'd0);
                j_next  = j_reg + 2'd1;
            end

            ST_TOP_RD:
                state_next = ST_FINISH;

            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    top_out_next   = (dcnt_reg == '0) ? '0 : CELL_W'($signed(data_rd_reg));
                    dd_out_next    = CNT_W'(dcnt_reg);
                    rd_out_next    = CNT_W'(rcnt_reg);
                    zf_out_next    = zf_reg && (flt_reg == FLT_OK);
                    flt_out_next   = flt_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dcnt_reg      <= '0;
            rcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            rcnt_reg      <= rcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        lit_reg     <= lit_next;
        nfetch_reg  <= nfetch_next;
        npush_reg   <= npush_next;
        k_reg       <= k_next;
        j_reg       <= j_next;
        base_reg    <= base_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        res_reg     <= res_next;
        acc_reg     <= acc_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        it_reg      <= it_next;
        zf_reg      <= zf_next;
        flt_reg     <= flt_next;
        top_out_reg <= top_out_next;
        dd_out_reg  <= dd_out_next;
        rd_out_reg  <= rd_out_next;
        zf_out_reg  <= zf_out_next;
        flt_out_reg <= flt_out_next;
    end

    `include "forth_two_stack_alu_core_assert.svh"

    `FTSA_ASSERT_NOW(a_depth_bound, clk, rst_n, 1'b1,
        dcnt_reg <= CW'(STACK_DEPTH) && rcnt_reg <= CW'(STACK_DEPTH))
    `FTSA_ASSERT_NOW(a_fault_clears, clk, rst_n, out_valid_reg && flt_out_reg != FLT_OK,
        dd_out_reg == '0 && rd_out_reg == '0 && top_out_reg == '0)
    `FTSA_ASSERT_NOW(a_zero_flag_ok, clk, rst_n, out_valid_reg && zf_out_reg,
        flt_out_reg == FLT_OK)
    `FTSA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req.valid && req.ready,
        state_reg != ST_IDLE)

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the two-stack Forth ALU. A queue of primitives (a directed
// opening, then lit-heavy random programs) is driven
// on the request channel. Each accepted request runs through a local
// two-stack predictor. Responses are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ftsa_pkg::*;

    localparam int DEPTH = 64;
    localparam logic [63:0] MAX_CELL = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MIN_CELL = 64'h8000_0000_0000_0000;

    typedef struct {
        op_t         op;
        logic [63:0] lit;
    } prim_t;

    typedef struct {
        logic [63:0] top;
        logic [6:0]  ddepth;
        logic [6:0]  rdepth;
        logic        zero;
        fault_t      flt;
    } status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ftsa_req_if req ();
    ftsa_rsp_if rsp ();

    forth_two_stack_alu_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    prim_t   prog_q[$];
    status_t status_q[$];
    int      errors = 0;
    int      accepted = 0;
    bit      req_taken = 0;
    int      send_idle = 28;
    int      recv_idle = 74;
    int      hold_cycles = 0;
    bit      hold_done = 0;

    // predictor state
    logic [63:0] dstk[DEPTH];
    logic [63:0] rstk[DEPTH];
    int          dcnt = 0;
    int          rcnt = 0;
    fault_t      pflt;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    function automatic void raise(fault_t f);
        if (pflt == FLT_OK)
            pflt = f;
    endfunction

    function automatic logic [63:0] dpop();
        if (pflt != FLT_OK) return 64'd0;
        if (dcnt == 0) begin raise(FLT_DATA_UNF); return 64'd0; end
        dcnt--;
        return dstk[dcnt];
    endfunction

    function automatic void dpush(logic [63:0] v);
        if (pflt != FLT_OK) return;
        if (dcnt >= DEPTH) begin raise(FLT_DATA_OVF); return; end
        dstk[dcnt] = v;
        dcnt++;
    endfunction

    function automatic logic [63:0] rpop();
        if (pflt != FLT_OK) return 64'd0;
        if (rcnt == 0) begin raise(FLT_RET_UNF); return 64'd0; end
        rcnt--;
        return rstk[rcnt];
    endfunction

    function automatic void rpush(logic [63:0] v);
        if (pflt != FLT_OK) return;
        if (rcnt >= DEPTH) begin raise(FLT_RET_OVF); return; end
        rstk[rcnt] = v;
        rcnt++;
    endfunction

    function automatic logic [63:0] absval(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] truth(bit c);
        return c ? '1 : 64'd0;
    endfunction

    function automatic void predict_status(prim_t p);
        logic [63:0] a, b, c;
        status_t     s;
        logic        zf;
        zf = 1'b0;
        pflt = FLT_OK;
        case (p.op)
            OP_LIT: dpush(p.lit);
            OP_ADD: begin b = dpop(); a = dpop(); dpush(a + b); end
            OP_SUB: begin b = dpop(); a = dpop(); dpush(a - b); end
            OP_MUL: begin b = dpop(); a = dpop(); dpush(a * b); end
            OP_DIV, OP_MOD:
            begin
                b = dpop(); a = dpop();
                if (pflt == FLT_OK) begin
                    if (b == 0)
                        raise(FLT_DIV_ZERO);
                    else if (p.op == OP_DIV) begin
                        c = absval(a) / absval(b);
                        dpush((a[63] ^ b[63]) ? -c : c);
                    end else begin
                        c = absval(a) % absval(b);
                        dpush(a[63] ? -c : c);
                    end
                end
            end
            OP_DUP: begin a = dpop(); dpush(a); dpush(a); end
            OP_2DUP: begin b = dpop(); a = dpop(); dpush(a); dpush(b); dpush(a); dpush(b); end
            OP_DROP: a = dpop();
            OP_2DROP: begin a = dpop(); a = dpop(); end
            OP_SWAP: begin b = dpop(); a = dpop(); dpush(b); dpush(a); end
            OP_NIP: begin b = dpop(); a = dpop(); dpush(b); end
            OP_TUCK: begin b = dpop(); a = dpop(); dpush(b); dpush(a); dpush(b); end
            OP_OVER: begin b = dpop(); a = dpop(); dpush(a); dpush(b); dpush(a); end
            OP_ROT: begin c = dpop(); b = dpop(); a = dpop(); dpush(b); dpush(c); dpush(a); end
            OP_PICK:
            begin
                a = dpop();
                if (pflt == FLT_OK) begin
                    if (a[63] || a >= dcnt)
                        raise(FLT_PICK);
                    else
                        dpush(dstk[dcnt - 1 - int'(a)]);
                end
            end
            OP_LSHIFT: begin b = dpop(); a = dpop(); dpush(b >= 64 ? 64'd0 : a << b); end
            OP_RSHIFT: begin b = dpop(); a = dpop(); dpush(b >= 64 ? 64'd0 : a >> b); end
            OP_EQ: begin b = dpop(); a = dpop(); dpush(truth(a == b)); end
            OP_LT: begin b = dpop(); a = dpop(); dpush(truth($signed(a) < $signed(b))); end
            OP_GT: begin b = dpop(); a = dpop(); dpush(truth($signed(a) > $signed(b))); end
            OP_TRUE: dpush('1);
            OP_FALSE: dpush(64'd0);
            OP_AND: begin b = dpop(); a = dpop(); dpush(a & b); end
            OP_OR: begin b = dpop(); a = dpop(); dpush(a | b); end
            OP_XOR: begin b = dpop(); a = dpop(); dpush(a ^ b); end
            OP_INVERT: begin a = dpop(); dpush(~a); end
            OP_NEGATE: begin a = dpop(); dpush(-a); end
            OP_TOR: begin a = dpop(); rpush(a); end
            OP_RFROM: begin a = rpop(); dpush(a); end
            OP_RFETCH:
            begin
                if (rcnt == 0)
                    raise(FLT_RET_UNF);
                else
                    dpush(rstk[rcnt - 1]);
            end
            default:
            begin
                a = dpop();
                if (pflt == FLT_OK)
                    zf = (a == 0);
            end
        endcase
        if (pflt != FLT_OK) begin
            dcnt = 0;
            rcnt = 0;
            zf = 1'b0;
        end
        s.top = dcnt ? dstk[dcnt - 1] : 64'd0;
        s.ddepth = 7'(dcnt);
        s.rdepth = 7'(rcnt);
        s.zero = zf;
        s.flt = pflt;
        status_q.push_back(s);
    endfunction

    function automatic logic [63:0] rand_cell();
        case ($urandom_range(0, 7))
            0: return MAX_CELL;
            1: return MIN_CELL;
            2: return 64'd0;
            3: return 64'($urandom_range(0, 70));
            4: return -64'($urandom_range(1, 70));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_prim(op_t op, logic [63:0] lit = 64'd0);
        prim_t p;
        p.op = op;
        p.lit = lit;
        prog_q.push_back(p);
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!req.valid || req_taken)) begin
            req_taken = 0;
            if (prog_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                prim_t p;
                p = prog_q.pop_front();
                req.func <= p.op;
                req.literal <= p.lit;
                req.valid <= 1'b1;
            end else begin
                req.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rst_n) begin
            if (!hold_done && accepted >= 100) begin
                hold_done = 1;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req.valid && req.ready) begin
                prim_t p;
                p.op = op_t'(req.func);
                p.lit = req.literal;
                predict_status(p);
                req_taken = 1;
                accepted++;
                if (accepted == 260) begin
                    send_idle = 74;
                    recv_idle = 28;
                end else if (accepted == 520) begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            end
            if (rsp.valid && rsp.ready) begin
                if (status_q.size() == 0) begin
                    report("unexpected response", rsp.top_value, 64'd0);
                end else begin
                    status_t s;
                    s = status_q.pop_front();
                    if (rsp.top_value !== s.top) report("top_value", rsp.top_value, s.top);
                    if (rsp.data_depth !== s.ddepth)
                        report("data_depth", rsp.data_depth, s.ddepth);
                    if (rsp.return_depth !== s.rdepth)
                        report("return_depth", rsp.return_depth, s.rdepth);
                    if (rsp.popped_zero !== s.zero)
                        report("popped_zero", rsp.popped_zero, s.zero);
                    if (rsp.fault !== s.flt) report("fault", rsp.fault, s.flt);
                end
            end
        end
    end

    initial
    begin
        int n;
        req.valid = 1'b0;
        req.func = '0;
        req.literal = '0;
        rsp.ready = 1'b0;

        // directed: empty-stack faults, extremes, division corners, shifts, pick range
        add_prim(OP_DROP);
        add_prim(OP_RFETCH);
        add_prim(OP_RFROM);
        add_prim(OP_LIT, MAX_CELL);
        add_prim(OP_LIT, MIN_CELL);
        add_prim(OP_ADD);
        add_prim(OP_LIT, 64'd0);
        add_prim(OP_DIV);
        add_prim(OP_LIT, MIN_CELL);
        add_prim(OP_LIT, '1);
        add_prim(OP_DIV);
        add_prim(OP_LIT, '1);
        add_prim(OP_MOD);
        add_prim(OP_LIT, 64'd5);
        add_prim(OP_LIT, 64'd64);
        add_prim(OP_LSHIFT);
        add_prim(OP_LIT, MIN_CELL);
        add_prim(OP_LIT, 64'd63);
        add_prim(OP_RSHIFT);
        add_prim(OP_LIT, '1);
        add_prim(OP_RSHIFT);
        add_prim(OP_LIT, 64'd9);
        add_prim(OP_PICK);
        add_prim(OP_ZTEST);

        // random: lit-heavy programs keep the stacks populated
        n = 0;
        while (n < 730) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 2) begin
                // fill the data stack past its top
                repeat (DEPTH + 1) add_prim(OP_LIT, rand_cell());
                n += DEPTH + 1;
            end else if (r < 4) begin
                // fill the return stack past its top
                repeat (DEPTH + 1)
                begin
                    add_prim(OP_LIT, rand_cell());
                    add_prim(OP_TOR);
                end
                n += 2 * DEPTH + 2;
            end else if (r < 38) begin
                add_prim(OP_LIT, rand_cell());
                n++;
            end else begin
                add_prim(op_t'($urandom_range(1, 31)), rand_cell());
                n++;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (prog_q.size() != 0 || req.valid || status_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ftsa_pkg.sv
hw/rtl/ftsa_req_if.sv
hw/rtl/ftsa_rsp_if.sv
hw/rtl/forth_two_stack_alu_core.sv
test/tb_top.sv
